// ----- design/pcnms_pkg.sv -----
package pcnms_pkg;

	localparam int LABEL_BITS = 8;
	localparam int SCORE_BITS = 16;
	localparam int OUT_COORD_BITS = 12;
	localparam int NCLS_BITS = 9;
	localparam int THR_BITS = 8;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [OUT_COORD_BITS-1:0] ocoord_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CLASSES = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_NUM = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESH_DEN = 2'd2;

	localparam logic [NCLS_BITS-1:0] NUM_CLASSES_RST = 9'd21;
	localparam logic [THR_BITS-1:0] THRESH_NUM_RST = 8'd3;
	localparam logic [THR_BITS-1:0] THRESH_DEN_RST = 8'd10;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_CLS_INIT,
		ST_GATH_START,
		ST_GATH_RD,
		ST_GATH_EV,
		ST_SORT_INIT,
		ST_SORT_RDI,
		ST_SORT_LDI,
		ST_SORT_RDJ,
		ST_SORT_CMP,
		ST_SORT_WRI,
		ST_NMS_INIT,
		ST_NMS_RDI,
		ST_NMS_LDI,
		ST_NMS_RDK,
		ST_NMS_P1,
		ST_NMS_P2,
		ST_NMS_P3,
		ST_NMS_P4,
		ST_NMS_P5,
		ST_KEEP,
		ST_NMS_NEXTI,
		ST_NEXT_CLS,
		ST_EMIT_START,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMPTY
	} state_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_CLS_INIT,
		OP_GATH_START,
		OP_GATH_EV,
		OP_SORT_INIT,
		OP_SORT_RDI,
		OP_SORT_LDI,
		OP_SORT_RDJ,
		OP_SORT_CMP,
		OP_SORT_WRI,
		OP_NMS_INIT,
		OP_NMS_LDI,
		OP_NMS_CHK,
		OP_KEEP,
		OP_NMS_NEXTI,
		OP_NEXT_CLS,
		OP_EMIT_START,
		OP_EMIT_LD,
		OP_EMPTY
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel_kept;
	} cmd_t;

	typedef struct packed {
		logic acc;
		logic last;
		logic numc_zero;
		logic gath_end;
		logic n_small;
		logic sort_i_end;
		logic sort_j_end;
		logic nc_zero;
		logic k_empty;
		logic k_end;
		logic close;
		logic i_end;
		logic found;
		logic nk_zero;
		logic out_free;
	} stat_t;

endpackage

// ----- design/pcnms_box_if.sv -----
interface pcnms_box_if #(
	parameter int COORD_BITS = 12
);
	logic valid;
	logic ready;
	logic [pcnms_pkg::LABEL_BITS-1:0] box_label;
	logic [pcnms_pkg::SCORE_BITS-1:0] box_score;
	logic [COORD_BITS-1:0] box_x;
	logic [COORD_BITS-1:0] box_y;
	logic [COORD_BITS-1:0] box_w;
	logic [COORD_BITS-1:0] box_h;
	logic in_last;

	modport source (
		output valid, box_label, box_score, box_x, box_y, box_w, box_h, in_last,
		input ready
	);
	modport sink (
		input valid, box_label, box_score, box_x, box_y, box_w, box_h, in_last,
		output ready
	);
endinterface

// ----- design/pcnms_res_if.sv -----
interface pcnms_res_if;
	logic valid;
	logic ready;
	logic out_valid;
	logic [pcnms_pkg::LABEL_BITS-1:0] out_label;
	logic [pcnms_pkg::SCORE_BITS-1:0] out_score;
	pcnms_pkg::ocoord_t out_x;
	pcnms_pkg::ocoord_t out_y;
	pcnms_pkg::ocoord_t out_w;
	pcnms_pkg::ocoord_t out_h;
	logic out_overflow;
	logic out_last;

	modport source (
		output valid, out_valid, out_label, out_score, out_x, out_y, out_w, out_h,
		output out_overflow, out_last,
		input ready
	);
	modport sink (
		input valid, out_valid, out_label, out_score, out_x, out_y, out_w, out_h,
		input out_overflow, out_last,
		output ready
	);
endinterface

// ----- design/pcnms_cfg_if.sv -----
interface pcnms_cfg_if;
	logic valid;
	logic ready;
	logic [pcnms_pkg::CFG_IDX_BITS-1:0] index;
	logic [pcnms_pkg::NCLS_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/pcnms_ctrl.sv -----
module pcnms_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  pcnms_pkg::stat_t stat,
	output pcnms_pkg::cmd_t cmd
);

	pcnms_pkg::state_t state_q, state_d;
	logic final_q, final_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcnms_pkg::ST_LOAD;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

	always_comb begin
		state_d = state_q;
		final_d = final_q;
		cmd.op = pcnms_pkg::OP_IDLE;
		cmd.sel_kept = final_q;
		case (state_q)
			pcnms_pkg::ST_LOAD: begin
				cmd.op = pcnms_pkg::OP_LOAD;
				if (stat.acc && stat.last) state_d = pcnms_pkg::ST_CLS_INIT;
			end
			pcnms_pkg::ST_CLS_INIT: begin
				cmd.op = pcnms_pkg::OP_CLS_INIT;
				final_d = stat.numc_zero;
				state_d = stat.numc_zero ? pcnms_pkg::ST_SORT_INIT : pcnms_pkg::ST_GATH_START;
			end
			pcnms_pkg::ST_GATH_START: begin
				cmd.op = pcnms_pkg::OP_GATH_START;
				state_d = pcnms_pkg::ST_GATH_RD;
			end
			pcnms_pkg::ST_GATH_RD: state_d = pcnms_pkg::ST_GATH_EV;
			pcnms_pkg::ST_GATH_EV: begin
				cmd.op = pcnms_pkg::OP_GATH_EV;
				state_d = stat.gath_end ? pcnms_pkg::ST_SORT_INIT : pcnms_pkg::ST_GATH_RD;
			end
			pcnms_pkg::ST_SORT_INIT: begin
				cmd.op = pcnms_pkg::OP_SORT_INIT;
				if (!stat.n_small) state_d = pcnms_pkg::ST_SORT_RDI;
				else if (final_q) state_d = pcnms_pkg::ST_EMIT_START;
				else state_d = pcnms_pkg::ST_NMS_INIT;
			end
			pcnms_pkg::ST_SORT_RDI: begin
				cmd.op = pcnms_pkg::OP_SORT_RDI;
				state_d = pcnms_pkg::ST_SORT_LDI;
			end
			pcnms_pkg::ST_SORT_LDI: begin
				cmd.op = pcnms_pkg::OP_SORT_LDI;
				state_d = pcnms_pkg::ST_SORT_RDJ;
			end
			pcnms_pkg::ST_SORT_RDJ: begin
				cmd.op = pcnms_pkg::OP_SORT_RDJ;
				state_d = pcnms_pkg::ST_SORT_CMP;
			end
			pcnms_pkg::ST_SORT_CMP: begin
				cmd.op = pcnms_pkg::OP_SORT_CMP;
				state_d = stat.sort_j_end ? pcnms_pkg::ST_SORT_WRI : pcnms_pkg::ST_SORT_RDJ;
			end
			pcnms_pkg::ST_SORT_WRI: begin
				cmd.op = pcnms_pkg::OP_SORT_WRI;
				if (!stat.sort_i_end) state_d = pcnms_pkg::ST_SORT_RDI;
				else if (final_q) state_d = pcnms_pkg::ST_EMIT_START;
				else state_d = pcnms_pkg::ST_NMS_INIT;
			end
			pcnms_pkg::ST_NMS_INIT: begin
				cmd.op = pcnms_pkg::OP_NMS_INIT;
				state_d = stat.nc_zero ? pcnms_pkg::ST_NEXT_CLS : pcnms_pkg::ST_NMS_RDI;
			end
			pcnms_pkg::ST_NMS_RDI: state_d = pcnms_pkg::ST_NMS_LDI;
			pcnms_pkg::ST_NMS_LDI: begin
				cmd.op = pcnms_pkg::OP_NMS_LDI;
				state_d = stat.k_empty ? pcnms_pkg::ST_KEEP : pcnms_pkg::ST_NMS_RDK;
			end
			pcnms_pkg::ST_NMS_RDK: state_d = pcnms_pkg::ST_NMS_P1;
			// overlap pipeline fills over these cycles
			pcnms_pkg::ST_NMS_P1: state_d = pcnms_pkg::ST_NMS_P2;
			pcnms_pkg::ST_NMS_P2: state_d = pcnms_pkg::ST_NMS_P3;
			pcnms_pkg::ST_NMS_P3: state_d = pcnms_pkg::ST_NMS_P4;
			pcnms_pkg::ST_NMS_P4: state_d = pcnms_pkg::ST_NMS_P5;
			pcnms_pkg::ST_NMS_P5: begin
				cmd.op = pcnms_pkg::OP_NMS_CHK;
				if (stat.close) state_d = pcnms_pkg::ST_NMS_NEXTI;
				else if (stat.k_end) state_d = pcnms_pkg::ST_KEEP;
				else state_d = pcnms_pkg::ST_NMS_RDK;
			end
			pcnms_pkg::ST_KEEP: begin
				cmd.op = pcnms_pkg::OP_KEEP;
				state_d = pcnms_pkg::ST_NMS_NEXTI;
			end
			pcnms_pkg::ST_NMS_NEXTI: begin
				cmd.op = pcnms_pkg::OP_NMS_NEXTI;
				state_d = stat.i_end ? pcnms_pkg::ST_NEXT_CLS : pcnms_pkg::ST_NMS_RDI;
			end
			pcnms_pkg::ST_NEXT_CLS: begin
				cmd.op = pcnms_pkg::OP_NEXT_CLS;
				if (stat.found) begin
					state_d = pcnms_pkg::ST_GATH_START;
				end else begin
					final_d = 1'b1;
					state_d = pcnms_pkg::ST_SORT_INIT;
				end
			end
			pcnms_pkg::ST_EMIT_START: begin
				cmd.op = pcnms_pkg::OP_EMIT_START;
				state_d = stat.nk_zero ? pcnms_pkg::ST_EMPTY : pcnms_pkg::ST_EMIT_RD;
			end
			pcnms_pkg::ST_EMIT_RD: state_d = pcnms_pkg::ST_EMIT_LD;
			pcnms_pkg::ST_EMIT_LD: begin
				cmd.op = pcnms_pkg::OP_EMIT_LD;
				if (stat.out_free)
					state_d = stat.k_end ? pcnms_pkg::ST_LOAD : pcnms_pkg::ST_EMIT_RD;
			end
			pcnms_pkg::ST_EMPTY: begin
				cmd.op = pcnms_pkg::OP_EMPTY;
				if (stat.out_free) state_d = pcnms_pkg::ST_LOAD;
			end
			default: state_d = pcnms_pkg::ST_LOAD;
		endcase
	end

endmodule

// ----- design/pcnms_dp.sv -----
module pcnms_dp #(
	parameter int MAX_BOXES = 64,
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  pcnms_pkg::cmd_t cmd,
	output pcnms_pkg::stat_t stat,
	pcnms_box_if.sink box,
	pcnms_res_if.source res,
	pcnms_cfg_if.sink cfg
);

	localparam int C = COORD_BITS;
	localparam int AW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int EW = 4 * C + pcnms_pkg::SCORE_BITS + pcnms_pkg::LABEL_BITS;
	localparam int OX = 0;
	localparam int OY = C;
	localparam int OW = 2 * C;
	localparam int OH = 3 * C;
	localparam int OS = 4 * C;
	localparam int OL = 4 * C + pcnms_pkg::SCORE_BITS;
	localparam int PW = 2 * C + 2;
	localparam int UW = 2 * C + 3;
	localparam int LW = PW + pcnms_pkg::THR_BITS;
	localparam int RW = UW + pcnms_pkg::THR_BITS;

	logic [EW-1:0] box_mem [MAX_BOXES];
	logic [EW-1:0] cand_mem [MAX_BOXES];
	logic [EW-1:0] kept_mem [MAX_BOXES];
	logic [EW-1:0] box_rd_q, cand_rd_q, kept_rd_q;

	logic [CW-1:0] cnt_q, nc_q, nk_q, start_q, i_q, j_q, k_q;
	logic ovf_q;
	logic [pcnms_pkg::LABEL_BITS-1:0] cls_q, nxt_q;
	logic found_q;
	logic [pcnms_pkg::NCLS_BITS-1:0] numc_q;
	logic [pcnms_pkg::THR_BITS-1:0] num_q, den_q;
	logic [EW-1:0] cur_q;
	logic rv_q;

	logic o_valid_q, o_ovf_q, o_last_q;
	logic [pcnms_pkg::LABEL_BITS-1:0] o_label_q;
	logic [pcnms_pkg::SCORE_BITS-1:0] o_score_q;
	pcnms_pkg::ocoord_t o_x_q, o_y_q, o_w_q, o_h_q;

	logic acc, out_free, store_ok, emit_go;
	logic [EW-1:0] in_entry, sort_rd;
	logic [CW-1:0] n_sel;
	logic [AW-1:0] box_raddr, cand_raddr, kept_raddr;
	logic cand_we, kept_we;
	logic [AW-1:0] cand_waddr, kept_waddr;
	logic [EW-1:0] cand_wdata, kept_wdata;
	logic [pcnms_pkg::LABEL_BITS-1:0] g_label;
	logic g_match, g_cand;
	logic swap;

	// overlap datapath
	logic [C-1:0] ax, ay, aw, ah, bx, by, bw, bh, x0, y0;
	logic [C:0] aex, aey, bex, bey, x1, y1;
	logic disj_s1, disj_s2, disj_s3, disj_s4;
	logic [C:0] dx_s1, dy_s1, aw1_s1, ah1_s1, bw1_s1, bh1_s1;
	logic [PW-1:0] inter_s2, aa_s2, ab_s2, inter_s3;
	logic [UW-1:0] uni_s3;
	logic [LW-1:0] lhs_s4;
	logic [RW-1:0] rhs_s4;

	assign acc = box.valid && box.ready;
	assign box.ready = (cmd.op == pcnms_pkg::OP_LOAD);
	assign cfg.ready = 1'b1;
	assign out_free = !rv_q || res.ready;
	assign emit_go = out_free
		&& ((cmd.op == pcnms_pkg::OP_EMIT_LD) || (cmd.op == pcnms_pkg::OP_EMPTY));
	assign store_ok = (cnt_q != CW'(MAX_BOXES));
	assign n_sel = cmd.sel_kept ? nk_q : nc_q;
	assign sort_rd = cmd.sel_kept ? kept_rd_q : cand_rd_q;
	assign swap = cur_q[OS +: pcnms_pkg::SCORE_BITS] < sort_rd[OS +: pcnms_pkg::SCORE_BITS];

	assign in_entry = {box.box_label, box.box_score, box.box_h, box.box_w, box.box_y, box.box_x};

	assign g_label = box_rd_q[OL +: pcnms_pkg::LABEL_BITS];
	assign g_match = (g_label == cls_q);
	assign g_cand = (g_label > cls_q) && ({1'b0, g_label} < numc_q)
		&& (!found_q || (g_label < nxt_q));

	assign box_raddr = i_q[AW-1:0];
	assign cand_raddr = (cmd.op == pcnms_pkg::OP_SORT_RDJ) ? j_q[AW-1:0] : i_q[AW-1:0];

	always_comb begin
		case (cmd.op)
			pcnms_pkg::OP_SORT_RDI: kept_raddr = i_q[AW-1:0];
			pcnms_pkg::OP_SORT_RDJ: kept_raddr = j_q[AW-1:0];
			default: kept_raddr = k_q[AW-1:0];
		endcase
	end

	always_comb begin
		cand_we = 1'b0;
		cand_waddr = nc_q[AW-1:0];
		cand_wdata = box_rd_q;
		kept_we = 1'b0;
		kept_waddr = nk_q[AW-1:0];
		kept_wdata = cur_q;
		case (cmd.op)
			pcnms_pkg::OP_GATH_EV: cand_we = g_match;
			pcnms_pkg::OP_SORT_CMP: begin
				cand_we = swap && !cmd.sel_kept;
				kept_we = swap && cmd.sel_kept;
				cand_waddr = j_q[AW-1:0];
				kept_waddr = j_q[AW-1:0];
				cand_wdata = cur_q;
			end
			pcnms_pkg::OP_SORT_WRI: begin
				cand_we = !cmd.sel_kept;
				kept_we = cmd.sel_kept;
				cand_waddr = i_q[AW-1:0];
				kept_waddr = i_q[AW-1:0];
				cand_wdata = cur_q;
			end
			pcnms_pkg::OP_KEEP: kept_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && store_ok) box_mem[cnt_q[AW-1:0]] <= in_entry;
		box_rd_q <= box_mem[box_raddr];
	end

	always_ff @(posedge clk) begin
		if (cand_we) cand_mem[cand_waddr] <= cand_wdata;
		cand_rd_q <= cand_mem[cand_raddr];
	end

	always_ff @(posedge clk) begin
		if (kept_we) kept_mem[kept_waddr] <= kept_wdata;
		kept_rd_q <= kept_mem[kept_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numc_q <= pcnms_pkg::NUM_CLASSES_RST;
			num_q <= pcnms_pkg::THRESH_NUM_RST;
			den_q <= pcnms_pkg::THRESH_DEN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				pcnms_pkg::REG_NUM_CLASSES: numc_q <= cfg.data;
				pcnms_pkg::REG_THRESH_NUM: num_q <= cfg.data[pcnms_pkg::THR_BITS-1:0];
				pcnms_pkg::REG_THRESH_DEN: den_q <= cfg.data[pcnms_pkg::THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			nc_q <= '0;
			nk_q <= '0;
			start_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cls_q <= '0;
			nxt_q <= '0;
			found_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			if (emit_go) rv_q <= 1'b1;
			else if (res.ready) rv_q <= 1'b0;
			case (cmd.op)
				pcnms_pkg::OP_LOAD: begin
					if (acc) begin
						if (store_ok) cnt_q <= cnt_q + CW'(1);
						else ovf_q <= 1'b1;
					end
				end
				pcnms_pkg::OP_CLS_INIT: begin
					cls_q <= '0;
					nk_q <= '0;
				end
				pcnms_pkg::OP_GATH_START: begin
					i_q <= '0;
					nc_q <= '0;
					found_q <= 1'b0;
				end
				pcnms_pkg::OP_GATH_EV: begin
					if (g_match) nc_q <= nc_q + CW'(1);
					if (g_cand) begin
						nxt_q <= g_label;
						found_q <= 1'b1;
					end
					i_q <= i_q + CW'(1);
				end
				pcnms_pkg::OP_SORT_INIT: i_q <= '0;
				pcnms_pkg::OP_SORT_LDI: j_q <= i_q + CW'(1);
				pcnms_pkg::OP_SORT_CMP: j_q <= j_q + CW'(1);
				pcnms_pkg::OP_SORT_WRI: i_q <= i_q + CW'(1);
				pcnms_pkg::OP_NMS_INIT: begin
					start_q <= nk_q;
					i_q <= '0;
				end
				pcnms_pkg::OP_NMS_LDI: k_q <= start_q;
				pcnms_pkg::OP_NMS_CHK: k_q <= k_q + CW'(1);
				pcnms_pkg::OP_KEEP: nk_q <= nk_q + CW'(1);
				pcnms_pkg::OP_NMS_NEXTI: i_q <= i_q + CW'(1);
				pcnms_pkg::OP_NEXT_CLS: cls_q <= nxt_q;
				pcnms_pkg::OP_EMIT_START: k_q <= '0;
				pcnms_pkg::OP_EMIT_LD: begin
					if (out_free) begin
						k_q <= k_q + CW'(1);
						if (stat.k_end) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							nc_q <= '0;
							nk_q <= '0;
						end
					end
				end
				pcnms_pkg::OP_EMPTY: begin
					if (out_free) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						nc_q <= '0;
						nk_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// working box and result payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			pcnms_pkg::OP_SORT_LDI: cur_q <= sort_rd;
			pcnms_pkg::OP_SORT_CMP: if (swap) cur_q <= sort_rd;
			pcnms_pkg::OP_NMS_LDI: cur_q <= cand_rd_q;
			default: ;
		endcase
		if (cmd.op == pcnms_pkg::OP_EMIT_LD && out_free) begin
			o_valid_q <= 1'b1;
			o_label_q <= kept_rd_q[OL +: pcnms_pkg::LABEL_BITS];
			o_score_q <= kept_rd_q[OS +: pcnms_pkg::SCORE_BITS];
			o_x_q <= pcnms_pkg::ocoord_t'(kept_rd_q[OX +: C]);
			o_y_q <= pcnms_pkg::ocoord_t'(kept_rd_q[OY +: C]);
			o_w_q <= pcnms_pkg::ocoord_t'(kept_rd_q[OW +: C]);
			o_h_q <= pcnms_pkg::ocoord_t'(kept_rd_q[OH +: C]);
			o_ovf_q <= ovf_q;
			o_last_q <= stat.k_end;
		end else if (cmd.op == pcnms_pkg::OP_EMPTY && out_free) begin
			o_valid_q <= 1'b0;
			o_label_q <= '0;
			o_score_q <= '0;
			o_x_q <= '0;
			o_y_q <= '0;
			o_w_q <= '0;
			o_h_q <= '0;
			o_ovf_q <= ovf_q;
			o_last_q <= 1'b1;
		end
	end

	assign res.valid = rv_q;
	assign res.out_valid = o_valid_q;
	assign res.out_label = o_label_q;
	assign res.out_score = o_score_q;
	assign res.out_x = o_x_q;
	assign res.out_y = o_y_q;
	assign res.out_w = o_w_q;
	assign res.out_h = o_h_q;
	assign res.out_overflow = o_ovf_q;
	assign res.out_last = o_last_q;

	// a = candidate in cur_q, b = kept box
	always_comb begin
		ax = cur_q[OX +: C];
		ay = cur_q[OY +: C];
		aw = cur_q[OW +: C];
		ah = cur_q[OH +: C];
		bx = kept_rd_q[OX +: C];
		by = kept_rd_q[OY +: C];
		bw = kept_rd_q[OW +: C];
		bh = kept_rd_q[OH +: C];
		aex = {1'b0, ax} + {1'b0, aw};
		aey = {1'b0, ay} + {1'b0, ah};
		bex = {1'b0, bx} + {1'b0, bw};
		bey = {1'b0, by} + {1'b0, bh};
		x0 = (ax > bx) ? ax : bx;
		y0 = (ay > by) ? ay : by;
		x1 = (aex < bex) ? aex : bex;
		y1 = (aey < bey) ? aey : bey;
	end

	always_ff @(posedge clk) begin
		disj_s1 <= ({1'b0, bx} > aex) || (bex < {1'b0, ax})
			|| ({1'b0, by} > aey) || (bey < {1'b0, ay});
		dx_s1 <= x1 - {1'b0, x0};
		dy_s1 <= y1 - {1'b0, y0};
		aw1_s1 <= {1'b0, aw} + (C+1)'(1);
		ah1_s1 <= {1'b0, ah} + (C+1)'(1);
		bw1_s1 <= {1'b0, bw} + (C+1)'(1);
		bh1_s1 <= {1'b0, bh} + (C+1)'(1);

		disj_s2 <= disj_s1;
		inter_s2 <= PW'(dx_s1) * PW'(dy_s1);
		aa_s2 <= PW'(aw1_s1) * PW'(ah1_s1);
		ab_s2 <= PW'(bw1_s1) * PW'(bh1_s1);

		disj_s3 <= disj_s2;
		inter_s3 <= inter_s2;
		uni_s3 <= UW'(aa_s2) + UW'(ab_s2) - UW'(inter_s2);

		disj_s4 <= disj_s3;
		lhs_s4 <= LW'(den_q) * LW'(inter_s3);
		rhs_s4 <= RW'(num_q) * RW'(uni_s3);
	end

	always_comb begin
		stat.acc = acc;
		stat.last = box.in_last;
		stat.numc_zero = (numc_q == '0);
		stat.gath_end = ({1'b0, i_q} + (CW+1)'(1)) == {1'b0, cnt_q};
		stat.n_small = (n_sel <= CW'(1));
		stat.sort_i_end = ({1'b0, i_q} + (CW+1)'(2)) == {1'b0, n_sel};
		stat.sort_j_end = ({1'b0, j_q} + (CW+1)'(1)) == {1'b0, n_sel};
		stat.nc_zero = (nc_q == '0);
		stat.k_empty = (start_q == nk_q);
		stat.k_end = ({1'b0, k_q} + (CW+1)'(1)) == {1'b0, nk_q};
		stat.close = !disj_s4 && (RW'(lhs_s4) > rhs_s4);
		stat.i_end = ({1'b0, i_q} + (CW+1)'(1)) == {1'b0, nc_q};
		stat.found = found_q;
		stat.nk_zero = (nk_q == '0);
		stat.out_free = out_free;
	end

`ifndef SYNTH
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n) nk_q <= cnt_q)
		else $error("kept count exceeds stored box count");
	a_cand_bound: assert property (@(posedge clk) disable iff (!arst_n) nc_q <= cnt_q)
		else $error("candidate count exceeds stored box count");
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		acc && box.in_last |=> !box.ready)
		else $error("input still open after frame closed");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && !o_valid_q |-> o_last_q)
		else $error("empty result not marked last");
`endif

endmodule

// ----- design/per_class_greedy_nms.sv -----
// frame processing starts after the last box request; per class, all stored boxes are
// scanned to gather the class's n boxes, these are exchange sorted by score and each
// candidate/kept pair gets an overlap check (4 stage overlap pipeline), then the K kept
// boxes get a final sort and are emitted as results.
// throughput: one box request per cycle while loading; frames are processed one at a time.
// reset: async active-low; counters, flags and registers (21, 3, 10) reset, stores do not.
module per_class_greedy_nms #(
	parameter int MAX_BOXES = 64,
	parameter int COORD_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	pcnms_box_if.sink box,
	pcnms_res_if.source res,
	pcnms_cfg_if.sink cfg
);

	pcnms_pkg::cmd_t cmd;
	pcnms_pkg::stat_t stat;

	pcnms_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cmd(cmd)
	);

	pcnms_dp #(
		.MAX_BOXES(MAX_BOXES),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.box(box),
		.res(res),
		.cfg(cfg)
	);

endmodule
